[rtl/pcc_pkg.sv]
// shared types, register indexes and saturation helper for the particle box collision block
// no dependencies; imported by pcc_resolve and particle_container_collision
`default_nettype none

package pcc_pkg;

    typedef logic signed [31:0] coord_t;
    typedef coord_t             vec3_t [3];
    typedef logic signed [32:0] diff_t;
    typedef logic signed [50:0] prod_t;
    typedef logic signed [35:0] wide_t;
    typedef logic        [16:0] frac_t;
    typedef logic        [1:0]  axis_t;
    typedef logic        [2:0]  reg_idx_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam reg_idx_t REG_FLOOR_LEVEL = 3'd0;
    localparam reg_idx_t REG_WALL_X_LOW  = 3'd1;
    localparam reg_idx_t REG_WALL_X_HIGH = 3'd2;
    localparam reg_idx_t REG_WALL_Z_LOW  = 3'd3;
    localparam reg_idx_t REG_WALL_Z_HIGH = 3'd4;
    localparam reg_idx_t REG_BOUNCE_LOSS = 3'd5;
    localparam reg_idx_t REG_SLIDE_LOSS  = 3'd6;
    localparam reg_idx_t REG_WALL_MARGIN = 3'd7;

    // 1.0 in Q1.16
    localparam frac_t ONE_Q16 = 17'd65536;

    localparam wide_t COORD_MAX = 36'sd2147483647;
    localparam wide_t COORD_MIN = -36'sd2147483648;

    // bounds of one collision check
    typedef struct packed {
        coord_t lo;
        coord_t hi;
        logic   use_hi;
    } bound_t;

    // response settings shared by all checks
    typedef struct packed {
        logic [15:0] margin;
        frac_t       kn;
        frac_t       kt;
    } resp_cfg_t;

    // clip a wide signed value to the 32 bit range
    function automatic coord_t sat32(input wide_t v);
        coord_t r;
        if (v > COORD_MAX)
            r = COORD_MAX[31:0];
        else if (v < COORD_MIN)
            r = COORD_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/particle_container_collision.sv]
// top level: config registers, beat unpacking and three chained collision checks
// depends on pcc_pkg and pcc_resolve
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       s_axis_tdata: cur xyz, old xyz
//  m_axis    out  m_axis_tvalid/tready       m_axis_tdata: new cur xyz, new old xyz
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one particle per cycle sustained while m_axis is not stalled; three checks of three stages
// the multiply stage of each check sets the stage depth
// reset clears the valid bits and loads the register defaults, no clearing pass
// a stall on m_axis fills bubbles first; s_axis_tready drops only when all stages are full
`default_nettype none

module particle_container_collision (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // cur_x, cur_y, cur_z, old_x, old_y, old_z (32 bits each)
    input  wire logic [191:0]   s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // new_cur_x, new_cur_y, new_cur_z, new_old_x, new_old_y, new_old_z (32 bits each)
    output logic      [191:0]   m_axis_tdata,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire pcc_pkg::reg_idx_t cfg_index,
    input  wire logic [31:0]    cfg_data
);
    import pcc_pkg::*;

    coord_t      floor_level_reg, wall_x_low_reg, wall_x_high_reg;
    coord_t      wall_z_low_reg, wall_z_high_reg;
    frac_t       bounce_loss_reg, slide_loss_reg;
    logic [15:0] wall_margin_reg;

    resp_cfg_t   rcfg;
    bound_t      bnd_floor, bnd_x, bnd_z;

    vec3_t       cur0, old0, cur1, old1, cur2, old2, cur3, old3;
    logic        v1, r1, v2, r2;

    // config write channel, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_level_reg <= 32'sd0;
            wall_x_low_reg  <= -32'sd131072;
            wall_x_high_reg <= 32'sd131072;
            wall_z_low_reg  <= -32'sd131072;
            wall_z_high_reg <= 32'sd131072;
            bounce_loss_reg <= 17'd0;
            slide_loss_reg  <= 17'd0;
            wall_margin_reg <= 16'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FLOOR_LEVEL: floor_level_reg <= cfg_data;
                REG_WALL_X_LOW:  wall_x_low_reg  <= cfg_data;
                REG_WALL_X_HIGH: wall_x_high_reg <= cfg_data;
                REG_WALL_Z_LOW:  wall_z_low_reg  <= cfg_data;
                REG_WALL_Z_HIGH: wall_z_high_reg <= cfg_data;
                REG_BOUNCE_LOSS: bounce_loss_reg <= cfg_data[16:0];
                REG_SLIDE_LOSS:  slide_loss_reg  <= cfg_data[16:0];
                REG_WALL_MARGIN: wall_margin_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // loss above one acts as one
    always_comb
    begin
        rcfg.margin = wall_margin_reg;
        rcfg.kn = ONE_Q16 - ((bounce_loss_reg > ONE_Q16) ? ONE_Q16 : bounce_loss_reg);
        rcfg.kt = ONE_Q16 - ((slide_loss_reg > ONE_Q16) ? ONE_Q16 : slide_loss_reg);
    end

    // check bounds, the floor has no upper side
    assign bnd_floor = '{lo: floor_level_reg, hi: floor_level_reg, use_hi: 1'b0};
    assign bnd_x     = '{lo: wall_x_low_reg, hi: wall_x_high_reg, use_hi: 1'b1};
    assign bnd_z     = '{lo: wall_z_low_reg, hi: wall_z_high_reg, use_hi: 1'b1};

    // unpack the input beat
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cur0[i] = s_axis_tdata[32*i +: 32];
            old0[i] = s_axis_tdata[96 + 32*i +: 32];
        end
    end

    // floor, then x walls, then z walls
    pcc_resolve u_floor (
        .clk(clk), .rst_n(rst_n), .axis(AXIS_Y), .bound(bnd_floor), .rcfg(rcfg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cur(cur0), .in_old(old0),
        .out_valid(v1), .out_ready(r1), .out_cur(cur1), .out_old(old1)
    );

    pcc_resolve u_wall_x (
        .clk(clk), .rst_n(rst_n), .axis(AXIS_X), .bound(bnd_x), .rcfg(rcfg),
        .in_valid(v1), .in_ready(r1), .in_cur(cur1), .in_old(old1),
        .out_valid(v2), .out_ready(r2), .out_cur(cur2), .out_old(old2)
    );

    pcc_resolve u_wall_z (
        .clk(clk), .rst_n(rst_n), .axis(AXIS_Z), .bound(bnd_z), .rcfg(rcfg),
        .in_valid(v2), .in_ready(r2), .in_cur(cur2), .in_old(old2),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_cur(cur3), .out_old(old3)
    );

    // pack the output beat
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_axis_tdata[32*i +: 32]      = cur3[i];
            m_axis_tdata[96 + 32*i +: 32] = old3[i];
        end
    end

endmodule

`default_nettype wire

[rtl/pcc_resolve.sv]
// one collision check (floor or wall pair) as a three stage pipeline with per-stage backpressure
// depends on pcc_pkg
`default_nettype none

module pcc_resolve (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pcc_pkg::axis_t     axis,
    input  wire pcc_pkg::bound_t    bound,
    input  wire pcc_pkg::resp_cfg_t rcfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pcc_pkg::vec3_t     in_cur,
    input  wire pcc_pkg::vec3_t     in_old,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pcc_pkg::vec3_t          out_cur,
    output pcc_pkg::vec3_t          out_old
);
    import pcc_pkg::*;

    // stage registers
    logic   a_v_reg, b_v_reg, c_v_reg;
    logic   a_hit_reg, b_hit_reg;
    vec3_t  a_cur_reg, a_old_reg, b_cur_reg, b_old_reg, c_cur_reg, c_old_reg;
    diff_t  a_s_reg [3];
    prod_t  b_p_reg [3];

    logic   en_a, en_b, en_c;

    // stage A combinational
    coord_t sel;
    logic   lo_hit, hi_hit, hit;
    coord_t target;
    vec3_t  cur_a;
    diff_t  diff [3];
    diff_t  s_a  [3];

    // stage C combinational
    vec3_t  old_c;

    // per-stage advance, a stage takes a beat when empty or when it empties
    assign en_c     = !c_v_reg || out_ready;
    assign en_b     = !b_v_reg || en_c;
    assign en_a     = !a_v_reg || en_b;
    assign in_ready = en_a;

    // compare, clamp and velocity
    always_comb
    begin
        sel = in_cur[0];
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) == axis)
                sel = in_cur[i];
        end
        lo_hit = sel < bound.lo;
        hi_hit = bound.use_hi && (sel > bound.hi);
        hit    = lo_hit || hi_hit;
        if (lo_hit)
            target = sat32(36'(bound.lo) + $signed({20'd0, rcfg.margin}));
        else
            target = sat32(36'(bound.hi) - $signed({20'd0, rcfg.margin}));
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) == axis && hit)
                cur_a[i] = target;
            else
                cur_a[i] = in_cur[i];
            diff[i] = 33'(cur_a[i]) - 33'(in_old[i]);
            if (2'(i) == axis)
                s_a[i] = -diff[i];
            else
                s_a[i] = diff[i];
        end
    end

    // shifted product back to position and saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_hit_reg)
                old_c[i] = sat32(36'(b_cur_reg[i]) - 36'($signed(b_p_reg[i][50:16])));
            else
                old_c[i] = b_old_reg[i];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_v_reg <= in_valid;
            if (en_b)
                b_v_reg <= a_v_reg;
            if (en_c)
                c_v_reg <= b_v_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_hit_reg <= hit;
            a_cur_reg <= cur_a;
            a_old_reg <= in_old;
            a_s_reg   <= s_a;
        end
        if (en_b)
        begin
            b_hit_reg <= a_hit_reg;
            b_cur_reg <= a_cur_reg;
            b_old_reg <= a_old_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) == axis)
                    b_p_reg[i] <= a_s_reg[i] * $signed({1'b0, rcfg.kn});
                else
                    b_p_reg[i] <= a_s_reg[i] * $signed({1'b0, rcfg.kt});
            end
        end
        if (en_c)
        begin
            c_cur_reg <= b_cur_reg;
            c_old_reg <= old_c;
        end
    end

    assign out_valid = c_v_reg;
    assign out_cur   = c_cur_reg;
    assign out_old   = c_old_reg;

    // backpressure only when every stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (a_v_reg && b_v_reg && c_v_reg))
        else $error("pcc_resolve: input stalled with a free stage");

    // a beat moving from B to C arrives in C
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_v_reg && en_c) |=> c_v_reg)
        else $error("pcc_resolve: beat lost between stages B and C");

    // a blocked beat in A keeps its hit decision
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_v_reg && !en_b) |=> (a_v_reg && $stable(a_hit_reg)))
        else $error("pcc_resolve: stalled stage A changed");

endmodule

`default_nettype wire

[test/particle_container_collision_tb.sv]
// self-checking bench for particle_container_collision: streams particles, predicts the
// floor and wall response in fixed point and compares every output beat in order
// depends on pcc_pkg and the particle_container_collision rtl
`default_nettype none

module particle_container_collision_tb;

    import pcc_pkg::*;

    localparam int    LATENCY     = 9;
    localparam int    CYCLE_LIMIT = 400000;
    localparam longint POS_MAX    = 64'sd2147483647;
    localparam longint POS_MIN    = -64'sd2147483648;

    // expected box response and the queue of resolved particles
    class resolve_checker;
        longint floor_lvl;
        longint x_lo;
        longint x_hi;
        longint z_lo;
        longint z_hi;
        longint bounce;
        longint slide;
        longint margin;
        longint pc[3];
        longint po[3];
        logic [191:0] resolved_q[$];
        int errors;
        int seen;

        function new();
            floor_lvl = 0;
            x_lo      = -131072;
            x_hi      = 131072;
            z_lo      = -131072;
            z_hi      = 131072;
            bounce    = 0;
            slide     = 0;
            margin    = 7;
            errors    = 0;
            seen      = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] data);
            case (idx)
                REG_FLOOR_LEVEL: floor_lvl = longint'($signed(data));
                REG_WALL_X_LOW:  x_lo      = longint'($signed(data));
                REG_WALL_X_HIGH: x_hi      = longint'($signed(data));
                REG_WALL_Z_LOW:  z_lo      = longint'($signed(data));
                REG_WALL_Z_HIGH: z_hi      = longint'($signed(data));
                REG_BOUNCE_LOSS: bounce    = longint'(data[16:0]);
                REG_SLIDE_LOSS:  slide     = longint'(data[15:0]) | (longint'(data[16]) << 16);
                REG_WALL_MARGIN: margin    = longint'(data[15:0]);
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > POS_MAX)
                return POS_MAX;
            if (v < POS_MIN)
                return POS_MIN;
            return v;
        endfunction

        // loss at or above one leaves no velocity at all
        function longint keep_factor(longint loss);
            return (loss > 65536) ? 0 : 65536 - loss;
        endfunction

        // clamp one axis, reflect its velocity, damp the other two
        function void bounce_axis(axis_t axis, longint target);
            longint vel;
            longint k;
            for (int i = 0; i < 3; i++)
            begin
                if (i == axis)
                    pc[i] = clip(target);
            end
            for (int i = 0; i < 3; i++)
            begin
                vel = pc[i] - po[i];
                if (i == axis)
                begin
                    vel = -vel;
                    k   = keep_factor(bounce);
                end
                else
                    k = keep_factor(slide);
                // arithmetic shift gives the floor of the scaled product
                vel   = (vel * k) >>> 16;
                po[i] = clip(pc[i] - vel);
            end
        endfunction

        function void note_particle(logic [191:0] beat);
            logic [191:0] want;
            for (int i = 0; i < 3; i++)
            begin
                pc[i] = longint'($signed(beat[32*i +: 32]));
                po[i] = longint'($signed(beat[32*(i+3) +: 32]));
            end
            // floor first, then x, then z, each on the updated particle
            if (pc[AXIS_Y] < floor_lvl)
                bounce_axis(AXIS_Y, floor_lvl + margin);
            if (pc[AXIS_X] < x_lo)
                bounce_axis(AXIS_X, x_lo + margin);
            else if (pc[AXIS_X] > x_hi)
                bounce_axis(AXIS_X, x_hi - margin);
            if (pc[AXIS_Z] < z_lo)
                bounce_axis(AXIS_Z, z_lo + margin);
            else if (pc[AXIS_Z] > z_hi)
                bounce_axis(AXIS_Z, z_hi - margin);
            for (int i = 0; i < 3; i++)
            begin
                want[32*i +: 32]     = pc[i][31:0];
                want[32*(i+3) +: 32] = po[i][31:0];
            end
            resolved_q = {resolved_q, want};
        endfunction

        task report_mismatch(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [191:0] beat);
            logic [191:0] want;
            string        part;
            string        axis_name;
            if (resolved_q.size() == 0)
                report_mismatch($sformatf("output beat %0d with no particle waiting", seen));
            else
            begin
                want = resolved_q.pop_front();
                for (int i = 0; i < 6; i++)
                begin
                    part      = (i < 3) ? "cur" : "old";
                    axis_name = (i % 3 == 0) ? "x" : (i % 3 == 1) ? "y" : "z";
                    if (beat[32*i +: 32] !== want[32*i +: 32])
                        report_mismatch($sformatf("beat %0d new_%s_%s got %0d want %0d",
                            seen, part, axis_name, $signed(beat[32*i +: 32]),
                            $signed(want[32*i +: 32])));
                end
            end
            seen++;
        endtask

        function int pending();
            return resolved_q.size();
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [191:0]   s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [191:0]   m_axis_tdata;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    reg_idx_t       cfg_index = REG_FLOOR_LEVEL;
    logic [31:0]    cfg_data = '0;

    resolve_checker board = new();
    bit             quiet = 1'b0;
    int             stall_left = 0;
    int             cycles = 0;

    particle_container_collision u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output beat checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // receiver back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [191:0] pack_particle(longint cx, longint cy, longint cz,
                                                   longint ox, longint oy, longint oz);
        return {oz[31:0], oy[31:0], ox[31:0], cz[31:0], cy[31:0], cx[31:0]};
    endfunction

    function automatic longint clip_pos(longint v);
        return (v > POS_MAX) ? POS_MAX : (v < POS_MIN) ? POS_MIN : v;
    endfunction

    // coordinate around a pair of bounds, with some fully random ones
    function automatic longint pick_coord(longint lo, longint hi);
        longint          offs;
        longint unsigned r;
        longint unsigned span;
        offs = longint'($urandom_range(0, 262144)) - 131072;
        case ($urandom_range(0, 9))
            0, 1:    return longint'($signed($urandom));
            2, 3:    return clip_pos(lo + offs);
            4, 5:    return clip_pos(hi + offs);
            default:
            begin
                if (lo > hi)
                    return clip_pos(lo + offs);
                span = longint'(hi - lo) + 1;
                r    = {$urandom, $urandom};
                return lo + longint'(r % span);
            end
        endcase
    endfunction

    // previous position: mostly a small step away from the current one
    function automatic longint pick_old(longint c);
        case ($urandom_range(0, 9))
            8:       return longint'($signed($urandom));
            9:       return c;
            default: return clip_pos(c + longint'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic longint pick_extreme();
        case ($urandom_range(0, 4))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return POS_MIN + 1;
            3:       return POS_MAX - 1;
            default: return 0;
        endcase
    endfunction

    // one particle beat, held until accepted; leaves tvalid high
    task automatic push_particle(logic [191:0] beat);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge clk); while (!s_axis_tready);
        board.note_particle(beat);
        @(negedge clk);
    endtask

    task automatic write_cfg(reg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
    endtask

    // full register set, written once the pipeline has drained
    task automatic program_box(longint fl, longint xl, longint xh, longint zl, longint zh,
                               longint bl, longint sl, longint mg);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        write_cfg(REG_FLOOR_LEVEL, fl[31:0]);
        write_cfg(REG_WALL_X_LOW,  xl[31:0]);
        write_cfg(REG_WALL_X_HIGH, xh[31:0]);
        write_cfg(REG_WALL_Z_LOW,  zl[31:0]);
        write_cfg(REG_WALL_Z_HIGH, zh[31:0]);
        write_cfg(REG_BOUNCE_LOSS, bl[31:0]);
        write_cfg(REG_SLIDE_LOSS,  sl[31:0]);
        write_cfg(REG_WALL_MARGIN, mg[31:0]);
        cfg_valid <= 1'b0;
    endtask

    // typical box, wild values, or extremes
    task automatic random_box(int flavour);
        longint w[8];
        case (flavour)
            0:
            begin
                w[0] = longint'($urandom_range(0, 524288)) - 262144;
                w[1] = -longint'($urandom_range(16384, 1048576));
                w[2] = longint'($urandom_range(16384, 1048576));
                w[3] = -longint'($urandom_range(16384, 1048576));
                w[4] = longint'($urandom_range(16384, 1048576));
                w[5] = $urandom_range(0, 65536);
                w[6] = $urandom_range(0, 65536);
                w[7] = $urandom_range(0, 65535);
            end
            1:
            begin
                for (int i = 0; i < 8; i++)
                    w[i] = longint'($urandom);
            end
            default:
            begin
                for (int i = 0; i < 5; i++)
                    w[i] = pick_extreme();
                w[5] = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 65536 : 131071);
                w[6] = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 65536 : 131071);
                w[7] = $urandom_range(0, 1) ? 0 : 65535;
            end
        endcase
        program_box(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]);
    endtask

    task automatic random_particles(int count);
        longint cx;
        longint cy;
        longint cz;
        for (int n = 0; n < count; n++)
        begin
            cx = pick_coord(board.x_lo, board.x_hi);
            cy = pick_coord(board.floor_lvl, board.floor_lvl + 262144);
            cz = pick_coord(board.z_lo, board.z_hi);
            push_particle(pack_particle(cx, cy, cz, pick_old(cx), pick_old(cy), pick_old(cz)));
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset box: no hit, each wall alone, all at once, bounds exactly, extremes
        push_particle(pack_particle(0, 65536, 0, 0, 65536, 0));
        push_particle(pack_particle(1000, -100, 2000, 1500, 1000, 1800));
        push_particle(pack_particle(-200000, 5000, 0, -190000, 5200, 300));
        push_particle(pack_particle(200000, 5000, 0, 190000, 4000, -300));
        push_particle(pack_particle(0, 5000, -200000, 700, 5000, -180000));
        push_particle(pack_particle(0, 5000, 200000, -700, 5000, 150000));
        push_particle(pack_particle(-200000, -5000, 200000, -100000, 1000, 100000));
        push_particle(pack_particle(-131072, 0, 131072, -131072, 0, 131072));
        push_particle(pack_particle(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
        push_particle(pack_particle(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
        push_particle(pack_particle(POS_MIN, POS_MIN, POS_MAX, 0, 0, 0));

        // floor at the top so the clamp overflows, crossed x walls, half bounce and quarter slide loss
        program_box(POS_MAX, 65536, -65536, POS_MIN, POS_MAX, 32768, 16384, 65535);
        push_particle(pack_particle(0, 0, 0, 100, 100, 100));
        push_particle(pack_particle(70000, POS_MIN, 5, -70000, POS_MAX, -5));
        push_particle(pack_particle(-70000, POS_MAX, POS_MIN, 0, POS_MAX - 3, POS_MAX));
        push_particle(pack_particle(POS_MAX, 12345, POS_MAX, POS_MIN, -54321, POS_MIN));
        push_particle(pack_particle(30000, -1, 0, 30000, -1, 0));

        // bounce loss of one, slide loss above one, crossed z walls, no margin
        program_box(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MIN, 65536, 131071, 0);
        push_particle(pack_particle(0, 0, 0, 9999, -9999, 9999));
        push_particle(pack_particle(POS_MAX, POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX));
        push_particle(pack_particle(POS_MIN, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN));
        push_particle(pack_particle(POS_MIN + 1, 7, POS_MAX - 1, 0, -7, 1));

        // random phases, the last two with no idling on either side
        for (int p = 0; p < 12; p++)
        begin
            random_box((p % 4 == 3) ? 2 : (p % 4 == 2) ? 1 : 0);
            if (p >= 10)
                quiet = 1'b1;
            random_particles(50);
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4 * LATENCY) @(negedge clk);

        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/pcc_pkg.sv
rtl/pcc_resolve.sv
rtl/particle_container_collision.sv
test/particle_container_collision_tb.sv
